// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the access id table. Both expect clk in scope; AIDT_ASSERT_CLK also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AIDT_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AIDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define AIDT_ASSERT_CLK(lbl, prop, msg)
`define AIDT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/aidt_pkg.sv =====
package aidt_pkg;

  localparam int unsigned AIDT_SLOTS = 16;
  localparam int unsigned MAX_LIST   = 16;
  localparam int unsigned DFLT_CARDS = 3;

  localparam logic [31:0] DFLT_ID0 = 32'h1234_5678;
  localparam logic [31:0] DFLT_ID1 = 32'h8765_4321;
  localparam logic [31:0] DFLT_ID2 = 32'hABCD_EF00;

  typedef enum logic [2:0] {
    OP_GET    = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_CHECK  = 3'd3,
    OP_LIST   = 3'd4,
    OP_FORMAT = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXISTS    = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // What the output register takes from the pending entry
  typedef enum logic [1:0] {
    RES_EMPTY = 2'd0,
    RES_SLOT  = 2'd1,
    RES_ENTRY = 2'd2
  } res_kind_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_HIT  = 2'd2,
    S_RESP = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic      start;
    logic      scan;
    logic      fmt;
    logic      capture;
    logic      upd;
    logic      step;
    logic      fill;
    logic      load_out;
    res_kind_t kind;
    status_t   status;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic hit;
    logic rd_active;
    logic scan_done;
    logic lim_zero;
    logic lim_reach;
    logic free_found;
    logic pend_vld;
    logic out_free;
  } dp_sts_t;

  function automatic logic [31:0] default_id(input logic [31:0] idx);
    logic [31:0] id;
    case (idx)
      32'd0:   id = DFLT_ID0;
      32'd1:   id = DFLT_ID1;
      32'd2:   id = DFLT_ID2;
      default: id = 32'd0;
    endcase
    return id;
  endfunction

endpackage

// ===== hw/rtl/aidt_if.sv =====
interface aidt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] card_id;
  logic [31:0] now;
  logic [4:0]  list_limit;

  modport source (output valid, output operation, output card_id, output now,
                  output list_limit, input ready);
  modport sink (input valid, input operation, input card_id, input now,
                input list_limit, output ready);
endinterface

interface aidt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slot;
  logic        entry_valid;
  logic [31:0] entry_id;
  logic [31:0] entry_time;
  logic [4:0]  active_count;
  logic        last;

  modport source (output valid, output status, output slot, output entry_valid,
                  output entry_id, output entry_time, output active_count,
                  output last, input ready);
  modport sink (input valid, input status, input slot, input entry_valid,
                input entry_id, input entry_time, input active_count,
                input last, output ready);
endinterface

// ===== hw/rtl/aidt_dp.sv =====
`include "assert_macros.svh"

module aidt_dp #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  aidt_pkg::dp_cmd_t cmd,
  output aidt_pkg::dp_sts_t sts,
  input  logic [2:0]        in_operation,
  input  logic [31:0]       in_card_id,
  input  logic [31:0]       in_now,
  input  logic [4:0]        in_list_limit,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [3:0]        out_slot,
  output logic              out_entry_valid,
  output logic [31:0]       out_entry_id,
  output logic [31:0]       out_entry_time,
  output logic [4:0]        out_active_count,
  output logic              out_last
);
  import aidt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0] DFLT_CNT = CNT_W'(DFLT_CARDS);
  localparam logic [TABLE_SLOTS-1:0] DFLT_ACT = TABLE_SLOTS'((1 << DFLT_CARDS) - 1);
  localparam logic [4:0] LIM_MAX = 5'(MAX_LIST);

  // Latched item
  op_t         op_r;
  logic [31:0] id_r;
  logic [31:0] now_r;
  logic [4:0]  lim_r;

  // Table storage; entries not yet written read as their reset contents
  logic [31:0] id_mem   [TABLE_SLOTS];
  logic [31:0] time_mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] id_wr_r;
  logic [TABLE_SLOTS-1:0] time_wr_r;
  logic [TABLE_SLOTS-1:0] act_r;
  logic [CNT_W-1:0]       cnt_r;

  // Scan pipeline
  logic [IDX_W-1:0] addr_r;
  logic             issue_en_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [31:0]      rd_id_q;
  logic [31:0]      rd_time_q;

  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;

  logic             pend_vld_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic [31:0]      pend_id_r;
  logic [31:0]      pend_time_r;
  logic [4:0]       list_n_r;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [3:0]  out_slot_r;
  logic        out_entry_valid_r;
  logic [31:0] out_entry_id_r;
  logic [31:0] out_entry_time_r;
  logic [4:0]  out_active_count_r;
  logic        out_last_r;

  logic [31:0]      rd_id_eff;
  logic [31:0]      rd_time_eff;
  logic             rd_active;
  logic             id_eq;
  logic             id_zero;
  logic             hit;
  logic             issue;
  logic             time_we;
  logic [IDX_W-1:0] time_wa;
  logic [4:0]       cnt_sat;

  always_comb begin
    rd_id_eff   = id_wr_r[rd_idx_r] ? rd_id_q : default_id(32'(rd_idx_r));
    rd_time_eff = time_wr_r[rd_idx_r] ? rd_time_q : 32'd0;
    rd_active   = act_r[rd_idx_r];
    id_eq       = (rd_id_eff == id_r);
    id_zero     = (rd_id_eff == 32'd0);
  end

  always_comb begin
    case (op_r) inside
      OP_GET:              hit = id_eq;
      OP_ADD:              hit = id_eq && (id_r != 32'd0);
      OP_REMOVE, OP_CHECK: hit = id_eq && rd_active;
      OP_LIST:             hit = rd_active && !id_zero;
      default:             hit = 1'b0;
    endcase
  end

  assign issue   = cmd.scan && issue_en_r;
  assign time_we = cmd.fill || (cmd.upd && (op_r == OP_CHECK));
  assign time_wa = cmd.fill ? free_idx_r : rd_idx_r;
  assign cnt_sat = (32'(cnt_r) > 32'd31) ? 5'd31 : 5'(cnt_r);

  always_comb begin
    sts.op         = op_r;
    sts.hit        = rd_vld_r && hit;
    sts.rd_active  = rd_active;
    sts.scan_done  = !issue_en_r && !rd_vld_r;
    sts.lim_zero   = (lim_r == 5'd0);
    sts.lim_reach  = ((list_n_r + 5'd1) == lim_r);
    sts.free_found = free_found_r;
    sts.pend_vld   = pend_vld_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      id_mem[free_idx_r] <= id_r;
    end
    if (time_we) begin
      time_mem[time_wa] <= now_r;
    end
    if (issue) begin
      rd_id_q   <= id_mem[addr_r];
      rd_time_q <= time_mem[addr_r];
      rd_idx_r  <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_wr_r      <= '0;
      time_wr_r    <= '0;
      act_r        <= DFLT_ACT;
      cnt_r        <= DFLT_CNT;
      addr_r       <= '0;
      issue_en_r   <= 1'b0;
      rd_vld_r     <= 1'b0;
      free_found_r <= 1'b0;
      pend_vld_r   <= 1'b0;
      list_n_r     <= 5'd0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (cmd.start) begin
        addr_r       <= '0;
        issue_en_r   <= 1'b1;
        free_found_r <= 1'b0;
        pend_vld_r   <= 1'b0;
        list_n_r     <= 5'd0;
      end else if (issue) begin
        addr_r <= addr_r + 1'b1;
        if (addr_r == LAST_IDX) begin
          issue_en_r <= 1'b0;
        end
      end
      // remember the first slot an add may fill
      if (rd_vld_r && (op_r == OP_ADD) && !free_found_r && (id_zero || !rd_active)) begin
        free_found_r <= 1'b1;
      end
      if (cmd.capture || cmd.fill) begin
        pend_vld_r <= 1'b1;
      end
      if (cmd.step) begin
        list_n_r <= list_n_r + 5'd1;
      end
      if (cmd.upd && (op_r == OP_REMOVE)) begin
        act_r[rd_idx_r] <= 1'b0;
        if (!id_zero) begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
      if (cmd.upd && (op_r == OP_CHECK)) begin
        time_wr_r[rd_idx_r] <= 1'b1;
      end
      if (cmd.fill) begin
        id_wr_r[free_idx_r]   <= 1'b1;
        time_wr_r[free_idx_r] <= 1'b1;
        act_r[free_idx_r]     <= 1'b1;
        if (id_r != 32'd0) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.fmt) begin
        id_wr_r   <= '0;
        time_wr_r <= '0;
        act_r     <= DFLT_ACT;
        cnt_r     <= DFLT_CNT;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= op_t'(in_operation);
      id_r  <= in_card_id;
      now_r <= in_now;
      lim_r <= (in_list_limit > LIM_MAX) ? LIM_MAX : in_list_limit;
    end
    if (rd_vld_r && !free_found_r && (id_zero || !rd_active)) begin
      free_idx_r <= rd_idx_r;
    end
    if (cmd.capture) begin
      pend_idx_r  <= rd_idx_r;
      pend_id_r   <= rd_id_eff;
      pend_time_r <= (op_r == OP_CHECK) ? now_r : rd_time_eff;
    end else if (cmd.fill) begin
      pend_idx_r  <= free_idx_r;
      pend_id_r   <= id_r;
      pend_time_r <= now_r;
    end
    if (cmd.load_out) begin
      out_status_r       <= cmd.status;
      out_active_count_r <= cnt_sat;
      out_last_r         <= cmd.last;
      case (cmd.kind)
        RES_ENTRY: begin
          out_slot_r        <= 4'(pend_idx_r);
          out_entry_valid_r <= 1'b1;
          out_entry_id_r    <= pend_id_r;
          out_entry_time_r  <= pend_time_r;
        end
        RES_SLOT: begin
          out_slot_r        <= 4'(pend_idx_r);
          out_entry_valid_r <= 1'b0;
          out_entry_id_r    <= 32'd0;
          out_entry_time_r  <= 32'd0;
        end
        default: begin
          out_slot_r        <= 4'd0;
          out_entry_valid_r <= 1'b0;
          out_entry_id_r    <= 32'd0;
          out_entry_time_r  <= 32'd0;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_entry_valid  = out_entry_valid_r;
  assign out_entry_id     = out_entry_id_r;
  assign out_entry_time   = out_entry_time_r;
  assign out_active_count = out_active_count_r;
  assign out_last         = out_last_r;

  `AIDT_ASSERT_CLK(a_cnt_range, 32'(cnt_r) <= TABLE_SLOTS, "active count exceeds table size")
  `AIDT_ASSERT_CLK(a_fmt_cnt, cmd.fmt |=> cnt_r == DFLT_CNT, "format did not restore count")
  `AIDT_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

// ===== hw/rtl/aidt_ctrl.sv =====
`include "assert_macros.svh"

module aidt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  aidt_pkg::dp_sts_t sts,
  output aidt_pkg::dp_cmd_t cmd
);
  import aidt_pkg::*;

  ctrl_state_t state_r, state_nxt;
  res_kind_t   res_kind_r, res_kind_nxt;
  status_t     res_status_r, res_status_nxt;

  logic sc_early;
  logic list_go;

  // Operations that finish without looking at the table: format, unused codes and a list with a zero limit
  always_comb begin
    unique case (sts.op)
      OP_GET, OP_ADD, OP_REMOVE, OP_CHECK: sc_early = 1'b0;
      OP_LIST:                             sc_early = sts.lim_zero;
      OP_FORMAT:                           sc_early = 1'b1;
      default:                             sc_early = 1'b1;
    endcase
  end

  // A held list entry must leave before the next one is captured
  assign list_go = !sts.pend_vld || sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sc_early) begin
          state_nxt = S_RESP;
        end else if (sts.hit) begin
          state_nxt = S_HIT;
        end else if (sts.scan_done) begin
          state_nxt = S_RESP;
        end
      end
      S_HIT: begin
        if (sts.op == OP_LIST) begin
          if (list_go) begin
            state_nxt = sts.lim_reach ? S_RESP : S_SCAN;
          end
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.kind       = RES_EMPTY;
    cmd.status     = ST_OK;
    in_ready       = 1'b0;
    res_kind_nxt   = res_kind_r;
    res_status_nxt = res_status_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_SCAN: begin
        if (sc_early) begin
          res_kind_nxt   = RES_EMPTY;
          res_status_nxt = ST_OK;
          unique case (sts.op)
            OP_FORMAT: cmd.fmt = 1'b1;
            OP_LIST:   res_status_nxt = ST_OK;
            default:   res_status_nxt = ST_NOT_FOUND;
          endcase
        end else if (sts.hit) begin
          cmd.scan = 1'b0;
        end else if (sts.scan_done) begin
          unique case (sts.op)
            OP_ADD: begin
              if (sts.free_found) begin
                cmd.fill       = 1'b1;
                res_kind_nxt   = RES_ENTRY;
                res_status_nxt = ST_OK;
              end else begin
                res_kind_nxt   = RES_EMPTY;
                res_status_nxt = ST_FULL;
              end
            end
            OP_LIST: begin
              res_kind_nxt   = sts.pend_vld ? RES_ENTRY : RES_EMPTY;
              res_status_nxt = ST_OK;
            end
            default: begin
              res_kind_nxt   = RES_EMPTY;
              res_status_nxt = ST_NOT_FOUND;
            end
          endcase
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_HIT: begin
        unique case (sts.op)
          OP_GET: begin
            cmd.capture    = 1'b1;
            res_kind_nxt   = sts.rd_active ? RES_ENTRY : RES_EMPTY;
            res_status_nxt = sts.rd_active ? ST_OK : ST_NOT_FOUND;
          end
          OP_ADD: begin
            cmd.capture    = 1'b1;
            res_kind_nxt   = RES_SLOT;
            res_status_nxt = ST_EXISTS;
          end
          OP_REMOVE: begin
            cmd.capture    = 1'b1;
            cmd.upd        = 1'b1;
            res_kind_nxt   = RES_SLOT;
            res_status_nxt = ST_OK;
          end
          OP_CHECK: begin
            cmd.capture    = 1'b1;
            cmd.upd        = 1'b1;
            res_kind_nxt   = RES_ENTRY;
            res_status_nxt = ST_OK;
          end
          OP_LIST: begin
            if (list_go) begin
              // push the previous entry, hold the new one until its successor shows
              cmd.load_out   = sts.pend_vld;
              cmd.kind       = RES_ENTRY;
              cmd.status     = ST_OK;
              cmd.last       = 1'b0;
              cmd.capture    = 1'b1;
              cmd.step       = 1'b1;
              res_kind_nxt   = RES_ENTRY;
              res_status_nxt = ST_OK;
            end
          end
          default: begin
            res_kind_nxt   = RES_EMPTY;
            res_status_nxt = ST_NOT_FOUND;
          end
        endcase
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.kind     = res_kind_r;
          cmd.status   = res_status_r;
          cmd.last     = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_kind_r   <= RES_EMPTY;
      res_status_r <= ST_OK;
    end else begin
      state_r      <= state_nxt;
      res_kind_r   <= res_kind_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  `AIDT_ASSERT_CLK(a_load_free, cmd.load_out |-> sts.out_free, "result loaded over a waiting item")
  `AIDT_ASSERT_CLK(a_start_clean, cmd.start |=> state_r == S_SCAN && !sts.pend_vld, "scan not armed")
  `AIDT_ASSERT_CLK(a_hit_next, state_r == S_SCAN && !sc_early && sts.hit |=> state_r == S_HIT, "hit lost")

endmodule

// ===== hw/rtl/access_id_table_core.sv =====
// Access id table: a table of card ids with an active bit and a timestamp per slot.
// Input channel in_ch carries one command item (get, add, remove, check, list,
// format) with card id, current time and list limit. Result channel out_ch carries
// result items with status, slot, entry fields, active count and a last flag.
// Every command gives one result item except list, which gives one per listed
// entry (at least one); the final item of a command has last set.
// Commands run one at a time. A command that scans the whole table reads one slot
// per cycle through the single read port of the id and time memories, then
// decides and loads its result; a hit ends the scan early except for list.
// Format, unused codes and a list with a zero limit skip the scan. A list pauses
// the scan at each entry it emits and waits there while the held entry cannot leave.
// Reset restores the three default cards in slots 0 to 2 at once; no clearing
// pass runs. When the receiver stalls, one result waits in the output register
// while the next command may already be taken; a list waits at the next entry.
module access_id_table_core #(
  parameter int unsigned TABLE_SLOTS = aidt_pkg::AIDT_SLOTS
) (
  input logic     clk,
  input logic     rst_n,
  aidt_in_if.sink   in_ch,
  aidt_out_if.source out_ch
);
  import aidt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  aidt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  aidt_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_ch.operation),
    .in_card_id       (in_ch.card_id),
    .in_now           (in_ch.now),
    .in_list_limit    (in_ch.list_limit),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_status       (out_ch.status),
    .out_slot         (out_ch.slot),
    .out_entry_valid  (out_ch.entry_valid),
    .out_entry_id     (out_ch.entry_id),
    .out_entry_time   (out_ch.entry_time),
    .out_active_count (out_ch.active_count),
    .out_last         (out_ch.last)
  );

  assign in_ch.ready = in_ready;

endmodule
